// ===== src/dip_pkg.sv =====
// shared types and constants for the decimal int64 parser
package dip_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 2;
    localparam int DIGIT_W  = 4;
    // accumulator extended so that value*10 +/- digit never wraps
    localparam int ACC_EXT_W = VALUE_W + 4;

    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    localparam logic [IDX_W-1:0] IDX_FIRST  = 2'd0;
    localparam logic [IDX_W-1:0] IDX_SECOND = 2'd1;
    localparam logic [IDX_W-1:0] IDX_LATER  = 2'd2;

    typedef enum logic [1:0] {
        SIGN_NONE  = 2'd0,
        SIGN_PLUS  = 2'd1,
        SIGN_MINUS = 2'd2
    } sign_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_LEADING_ZERO = 2'd1,
        ST_NEG_ZERO     = 2'd2,
        ST_MALFORMED    = 2'd3
    } status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

endpackage

// ===== src/dip_in_stage.sv =====
// input register for one character transaction
module dip_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  dip_pkg::item_t s_item,
    input  logic          advance,
    output logic          item_valid,
    output dip_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    dip_pkg::item_t item_reg;

    // free slot when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/dip_core.sv =====
// parse state and single-pass digit step with overflow and status checks
module dip_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  dip_pkg::item_t   item,
    input  logic             out_ready,
    output logic             advance,
    output logic             result_load,
    output dip_pkg::result_t result
);

    logic [dip_pkg::VALUE_W-1:0]   acc_reg, acc_next;
    logic [dip_pkg::IDX_W-1:0]     idx_reg, idx_next;
    dip_pkg::sign_t                sign_reg, sign_next;
    logic                          first_zero_reg, first_zero_next;
    logic                          second_zero_reg, second_zero_next;
    logic                          malformed_reg, malformed_next;

    logic                          is_digit;
    logic                          is_sign;
    logic                          is_first;
    logic                          neg;
    logic [dip_pkg::DIGIT_W-1:0]   digit;
    logic [dip_pkg::CHAR_W-1:0]    char_off;
    logic [dip_pkg::ACC_EXT_W-1:0] acc_ext;
    logic [dip_pkg::ACC_EXT_W-1:0] acc_x10;
    logic [dip_pkg::ACC_EXT_W-1:0] digit_ext;
    logic [dip_pkg::ACC_EXT_W-1:0] acc_sum;
    logic                          ovf;
    dip_pkg::status_t              status;

    // a held item moves on unless it is a final one facing a full output
    assign advance     = item_valid && (!item.is_last || out_ready);
    assign result_load = advance && item.is_last;

    // character decode
    assign is_digit = (item.char_code >= dip_pkg::CHAR_0) && (item.char_code <= dip_pkg::CHAR_9);
    assign is_sign  = (item.char_code == dip_pkg::CHAR_PLUS)
                   || (item.char_code == dip_pkg::CHAR_MINUS);
    assign is_first = (idx_reg == dip_pkg::IDX_FIRST);
    assign char_off = item.char_code - dip_pkg::CHAR_0;
    assign digit    = char_off[dip_pkg::DIGIT_W-1:0];
    assign neg      = (sign_reg == dip_pkg::SIGN_MINUS);

    // acc*10 +/- digit in extended width, out of range when top bits disagree
    assign acc_ext   = {{(dip_pkg::ACC_EXT_W-dip_pkg::VALUE_W){acc_reg[dip_pkg::VALUE_W-1]}},
                        acc_reg};
    assign acc_x10   = (acc_ext << 3) + (acc_ext << 1);
    assign digit_ext = {{(dip_pkg::ACC_EXT_W-dip_pkg::DIGIT_W){1'b0}}, digit};
    assign acc_sum   = neg ? (acc_x10 - digit_ext) : (acc_x10 + digit_ext);
    assign ovf       = !((&acc_sum[dip_pkg::ACC_EXT_W-1:dip_pkg::VALUE_W-1])
                      || (~|acc_sum[dip_pkg::ACC_EXT_W-1:dip_pkg::VALUE_W-1]));

    // state update for the current character
    always_comb begin
        acc_next         = acc_reg;
        sign_next        = sign_reg;
        first_zero_next  = first_zero_reg;
        second_zero_next = second_zero_reg;
        malformed_next   = malformed_reg;
        idx_next         = (idx_reg == dip_pkg::IDX_LATER) ? idx_reg : idx_reg + 1'b1;

        if (is_first) begin
            first_zero_next = (item.char_code == dip_pkg::CHAR_0);
        end
        if (idx_reg == dip_pkg::IDX_SECOND) begin
            second_zero_next = (item.char_code == dip_pkg::CHAR_0);
        end

        if (is_first && is_sign) begin
            sign_next = (item.char_code == dip_pkg::CHAR_MINUS) ? dip_pkg::SIGN_MINUS
                                                                : dip_pkg::SIGN_PLUS;
        end else if (!is_digit) begin
            malformed_next = 1'b1;
        end else if (!malformed_reg) begin
            if (ovf) begin
                malformed_next = 1'b1;
            end else begin
                acc_next = acc_sum[dip_pkg::VALUE_W-1:0];
            end
        end
    end

    // final status, negative zero first, then leading zeros, then malformed
    always_comb begin
        if ((sign_next == dip_pkg::SIGN_MINUS) && second_zero_next
                && (idx_reg == dip_pkg::IDX_SECOND)) begin
            status = dip_pkg::ST_NEG_ZERO;
        end else if ((first_zero_next && !is_first)
                || ((sign_next == dip_pkg::SIGN_MINUS) && second_zero_next)) begin
            status = dip_pkg::ST_LEADING_ZERO;
        end else if (malformed_next || ((sign_next != dip_pkg::SIGN_NONE) && is_first)) begin
            status = dip_pkg::ST_MALFORMED;
        end else begin
            status = dip_pkg::ST_OK;
        end
    end

    assign result.status = status;
    assign result.value  = (status == dip_pkg::ST_OK) ? acc_next : '0;

    // state registers, cleared after each final character
    always_ff @(posedge aclk) begin
        if (!aresetn || result_load) begin
            acc_reg         <= '0;
            idx_reg         <= dip_pkg::IDX_FIRST;
            sign_reg        <= dip_pkg::SIGN_NONE;
            first_zero_reg  <= 1'b0;
            second_zero_reg <= 1'b0;
            malformed_reg   <= 1'b0;
        end else if (advance) begin
            acc_reg         <= acc_next;
            idx_reg         <= idx_next;
            sign_reg        <= sign_next;
            first_zero_reg  <= first_zero_next;
            second_zero_reg <= second_zero_next;
            malformed_reg   <= malformed_next;
        end
    end

endmodule

// ===== src/dip_out_stage.sv =====
// result register holding one transaction for the master side
module dip_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             result_load,
    input  dip_pkg::result_t result,
    output logic             out_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output dip_pkg::result_t m_result
);

    logic             valid_reg;
    logic             valid_next;
    dip_pkg::result_t result_reg;

    // room for a new result when empty or when the held one leaves now
    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (result_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (result_load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== src/decimal_int64_parser.sv =====
// Decimal int64 parser: takes an integer literal one ASCII character per transaction
// (tlast on the final character), optional leading '+' or '-', and returns one result
// on the final character with the signed 64-bit value and a status (0 ok, 1 leading
// zeros, 2 negative zero, 3 malformed or overflow; value is zero unless status is 0).
// One character is taken every cycle unless a final character waits on a full result
// register. The multiply-by-ten, add and range check on the 64-bit accumulator are
// combinational between the input and result registers.
module decimal_int64_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] value, [65:64] status, [71:66] zero
);

    dip_pkg::item_t   s_item;
    dip_pkg::item_t   item;
    dip_pkg::result_t result;
    dip_pkg::result_t m_result;
    logic             item_valid;
    logic             advance;
    logic             result_load;
    logic             out_ready;

    assign s_item.char_code = s_tdata;
    assign s_item.is_last   = s_tlast;

    dip_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dip_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .item        (item),
        .out_ready   (out_ready),
        .advance     (advance),
        .result_load (result_load),
        .result      (result)
    );

    dip_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .result_load (result_load),
        .result      (result),
        .out_ready   (out_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (m_result)
    );

    assign m_tdata = {6'b0, m_result.status, m_result.value};

`ifndef SYNTHESIS
    // an error status never carries a value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[65:64] != dip_pkg::ST_OK)) |-> (m_tdata[63:0] == 64'd0))
        else $error("nonzero value with error status");

    // a final character that moves on always shows up as a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.is_last) |=> m_tvalid)
        else $error("final character did not produce a result");

    // a final character never overwrites a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !result_load)
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for decimal_int64_parser with a stream driver, predictor and scoreboard
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 12;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYC    = 300;
    localparam int RANDOM_CHARS = 740;
    localparam int MAX_REPORTS = 10;

    localparam logic [dip_pkg::VALUE_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [dip_pkg::VALUE_W-1:0] NEG_MAG = 64'h8000_0000_0000_0000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_code
    logic        s_tlast  = 1'b0;    // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;            // [63:0] value, [65:64] status, [71:66] zero

    // parser state mirrored by the predictor
    logic [dip_pkg::VALUE_W-1:0] run_total;
    logic [dip_pkg::IDX_W-1:0]   char_pos;
    dip_pkg::sign_t              sign_seen;
    logic                        lead_zero;
    logic                        next_zero;
    logic                        bad_literal;

    dip_pkg::result_t expected_values[$];
    logic [7:0]  literal_chars[$];
    int          mismatch_count = 0;
    int          chars_sent     = 0;
    int          cycle_count    = 0;
    int          ready_wait     = 0;
    bit          src_gaps       = 1'b1;
    bit          sink_gaps      = 1'b1;
    logic        hold_active    = 1'b0;
    event        hold_start;

    decimal_int64_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // run watchdog
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // predictor: state back to idle after each literal
    function automatic void clear_parse();
        run_total   = '0;
        char_pos    = dip_pkg::IDX_FIRST;
        sign_seen   = dip_pkg::SIGN_NONE;
        lead_zero   = 1'b0;
        next_zero   = 1'b0;
        bad_literal = 1'b0;
    endfunction

    // predictor: fold one digit into the running total with range check
    function automatic void add_digit(input logic [7:0] ch);
        logic [dip_pkg::VALUE_W-1:0] digit;
        logic [dip_pkg::VALUE_W-1:0] mag;
        logic [dip_pkg::VALUE_W-1:0] bound;
        logic                        neg;
        neg = (sign_seen == dip_pkg::SIGN_MINUS);
        if (ch < dip_pkg::CHAR_0 || ch > dip_pkg::CHAR_9) begin
            bad_literal = 1'b1;
            return;
        end
        if (bad_literal)
            return;
        digit = dip_pkg::VALUE_W'(ch - dip_pkg::CHAR_0);
        mag   = neg ? -run_total : run_total;
        bound = neg ? NEG_MAG : POS_MAX;
        if (mag > (bound - digit) / 10) begin
            bad_literal = 1'b1;
            return;
        end
        mag       = mag * 10 + digit;
        run_total = neg ? -mag : mag;
    endfunction

    // predictor: one accepted character, queues the value on the last one
    function automatic void parse_char(input logic [7:0] ch, input logic last);
        logic [dip_pkg::IDX_W-1:0] at;
        dip_pkg::status_t          st;
        dip_pkg::result_t          res;
        logic                      minus;
        at = char_pos;
        if (at == dip_pkg::IDX_FIRST) begin
            lead_zero = (ch == dip_pkg::CHAR_0);
            if (ch == dip_pkg::CHAR_PLUS)
                sign_seen = dip_pkg::SIGN_PLUS;
            else if (ch == dip_pkg::CHAR_MINUS)
                sign_seen = dip_pkg::SIGN_MINUS;
            else
                add_digit(ch);
        end else begin
            if (at == dip_pkg::IDX_SECOND)
                next_zero = (ch == dip_pkg::CHAR_0);
            add_digit(ch);
        end
        if (char_pos != dip_pkg::IDX_LATER)
            char_pos = char_pos + 1'b1;
        if (!last)
            return;
        minus = (sign_seen == dip_pkg::SIGN_MINUS);
        if (minus && next_zero && at == dip_pkg::IDX_SECOND)
            st = dip_pkg::ST_NEG_ZERO;
        else if ((lead_zero && at != dip_pkg::IDX_FIRST) || (minus && next_zero))
            st = dip_pkg::ST_LEADING_ZERO;
        else if (bad_literal || (sign_seen != dip_pkg::SIGN_NONE && at == dip_pkg::IDX_FIRST))
            st = dip_pkg::ST_MALFORMED;
        else
            st = dip_pkg::ST_OK;
        res.value  = (st == dip_pkg::ST_OK) ? run_total : '0;
        res.status = st;
        expected_values.push_back(res);
        clear_parse();
    endfunction

    // scoreboard compare of one result transaction
    task automatic check_value(input logic [71:0] beat);
        dip_pkg::result_t want;
        if (expected_values.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
                $display("unexpected result: value %0d status %0d",
                         $signed(beat[63:0]), beat[65:64]);
            mismatch_count = mismatch_count + 1;
        end else begin
            want = expected_values.pop_front();
            if (beat[63:0] !== want.value || beat[65:64] !== want.status) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                             $signed(want.value), want.status,
                             $signed(beat[63:0]), beat[65:64]);
                mismatch_count = mismatch_count + 1;
            end
        end
    endtask

    // result side: random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_value(m_tdata);
                ready_wait = sink_gaps ? $urandom_range(0, 16) : 0;
            end
            if (hold_active || ready_wait != 0) begin
                m_tready <= 1'b0;
                if (!hold_active)
                    ready_wait = ready_wait - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(hold_start);
            hold_active <= 1'b1;
            repeat (HOLD_CYC) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    // drive one character and wait for its transaction
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = src_gaps ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_char(ch, last);
        chars_sent = chars_sent + 1;
    endtask

    task automatic send_literal();
        foreach (literal_chars[i])
            send_char(literal_chars[i], i == literal_chars.size() - 1);
        literal_chars.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            literal_chars.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_literal();
    endtask

    task automatic add_sign(input int pick);
        if (pick == 1)
            literal_chars.push_back(dip_pkg::CHAR_PLUS);
        else if (pick == 2)
            literal_chars.push_back(dip_pkg::CHAR_MINUS);
    endtask

    task automatic add_digits(input int count, input bit nonzero_first);
        for (int i = 0; i < count; i++)
            literal_chars.push_back(8'(dip_pkg::CHAR_0 + ((i == 0 && nonzero_first) ?
                                    $urandom_range(1, 9) : $urandom_range(0, 9))));
    endtask

    // one random literal, mostly well-formed, some broken or pure noise
    task automatic build_literal();
        int                          kind;
        int                          len;
        int                          k;
        logic [dip_pkg::VALUE_W-1:0] mag;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            add_sign($urandom_range(0, 2));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 24) : $urandom_range(1, 19);
            add_digits(len, 1'b1);
        end else if (kind < 60) begin
            // values right at and just past the signed 64-bit range
            k = $urandom_range(0, 9);
            case ($urandom_range(0, 4))
                0: begin add_sign($urandom_range(0, 1)); mag = POS_MAX - k; end
                1: begin add_sign(2); mag = NEG_MAG - k; end
                2: begin add_sign($urandom_range(0, 1)); mag = NEG_MAG + k; end
                3: begin add_sign(2); mag = NEG_MAG + 1 + k; end
                default: begin add_sign($urandom_range(0, 2)); mag = '1 - k; end
            endcase
            add_text($sformatf("%0d", mag));
        end else if (kind < 70) begin
            // leading zero forms
            add_sign($urandom_range(0, 2));
            literal_chars.push_back(dip_pkg::CHAR_0);
            add_digits($urandom_range(0, 4), 1'b0);
        end else if (kind < 80) begin
            // short numbers, bare signs
            add_sign($urandom_range(0, 2));
            if (literal_chars.size() == 0 || $urandom_range(0, 4) != 0)
                add_text($sformatf("%0d", $urandom_range(0, 99)));
        end else if (kind < 90) begin
            // well-formed number with one random byte dropped in
            add_sign($urandom_range(0, 2));
            add_digits($urandom_range(1, 12), 1'b1);
            literal_chars[$urandom_range(0, literal_chars.size() - 1)] =
                8'($urandom_range(0, 255));
        end else begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                literal_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // sign rules, zero forms, bad characters and byte extremes
    task automatic test_special_cases();
        send_text("0");
        send_text("-0");
        send_text("00");
        send_text("-05");
        send_text("+0");
        send_text("+");
        send_text("-");
        send_text("7");
        send_text("1a");
        send_text("+-");
        send_text("12-");
        literal_chars.push_back(8'h00);
        send_literal();
        literal_chars.push_back(8'hFF);
        send_literal();
    endtask

    // receiver holds off while the sender keeps offering characters
    task automatic test_back_pressure();
        src_gaps = 1'b0;
        -> hold_start;
        for (int i = 0; i < 60; i++) begin
            add_sign($urandom_range(0, 1));
            add_digits(1, 1'b0);
            send_literal();
        end
        src_gaps = 1'b1;
    endtask

    // random literals with idle modes switched in blocks
    task automatic test_random_literals();
        int start_count;
        int lit_count;
        start_count = chars_sent;
        lit_count   = 0;
        while (chars_sent - start_count < RANDOM_CHARS) begin
            if (lit_count % 20 == 0) begin
                src_gaps  = ($urandom_range(0, 2) != 0);
                sink_gaps = ($urandom_range(0, 2) != 0);
            end
            build_literal();
            send_literal();
            lit_count = lit_count + 1;
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // test sequence
    initial begin
        clear_parse();
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_cases();
        test_back_pressure();
        test_random_literals();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_values.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== decimal_int64_parser.f =====
src/dip_pkg.sv
src/dip_in_stage.sv
src/dip_core.sv
src/dip_out_stage.sv
src/decimal_int64_parser.sv
sim/testbench.sv
